// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the timer unit.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ccdt_pkg.sv =====
// Package for the clock / stopwatch / countdown timer unit.
// Holds payload structs, command and mode codes, and time constants.
`timescale 1ns / 1ps

package ccdt_pkg;

  // Sizes
  localparam int FIFO_DEPTH = 2;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  // Request types
  localparam logic [1:0] REQ_TICK       = 2'd0;
  localparam logic [1:0] REQ_KEY        = 2'd1;
  localparam logic [1:0] REQ_START_STOP = 2'd2;

  // Key codes
  localparam logic [3:0] KEY_SEC_UP    = 4'd1;
  localparam logic [3:0] KEY_SEC_DN    = 4'd2;
  localparam logic [3:0] KEY_MIN_UP    = 4'd3;
  localparam logic [3:0] KEY_MIN_DN    = 4'd4;
  localparam logic [3:0] KEY_HOUR_UP   = 4'd5;
  localparam logic [3:0] KEY_HOUR_DN   = 4'd6;
  localparam logic [3:0] KEY_RUN_SET   = 4'd7;
  localparam logic [3:0] KEY_NEXT_MODE = 4'd8;

  // Register indexes on the config port
  localparam logic REG_TICK_STEP = 1'b0;
  localparam logic REG_MIN_STOP  = 1'b1;

  // Register reset values
  localparam logic [6:0] TICK_STEP_RST = 7'd5;
  localparam logic [5:0] MIN_STOP_RST  = 6'd3;

  // Time limits
  localparam logic [10:0] MS_PER_S  = 11'd1000;
  localparam logic [9:0]  MS_MAX    = 10'd999;
  localparam logic [5:0]  SM_MAX    = 6'd59;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [6:0]  STEP_MAX  = 7'd99;

  typedef enum logic [1:0] {
    MODE_TIMER     = 2'd0,
    MODE_STOPWATCH = 2'd1,
    MODE_CLOCK     = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_SEC_UP,
    CMD_SEC_DN,
    CMD_MIN_UP,
    CMD_MIN_DN,
    CMD_HOUR_UP,
    CMD_HOUR_DN,
    CMD_RUN_SET,
    CMD_NEXT_MODE,
    CMD_START_STOP
  } cmd_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] key_code;
  } item_t;

  typedef struct packed {
    logic [1:0] shown_mode;
    logic [4:0] shown_hours;
    logic [5:0] shown_minutes;
    logic [5:0] shown_seconds;
    logic [9:0] shown_millis;
    logic       alarm_active;
    logic       stopwatch_running;
    logic       countdown_running;
  } result_t;

  typedef struct packed {
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] s;
    logic [9:0] ms;
  } hms_t;

  typedef struct packed {
    logic [6:0] tick_step;
    logic [5:0] min_stop;
  } cfg_t;

endpackage

// ===== rtl/core/clock_stopwatch_countdown_timer_unit.sv =====
// Top level of the clock / stopwatch / countdown timer unit.
// Depends on ccdt_pkg, ccdt_front, ccdt_fifo, ccdt_back and ccdt_regs.
//
//  channel   direction  handshake              payload
//  item      in         push / full            item_i   (item_t)
//  result    out        pop / empty            result_o (result_t)
//  config    in         psel/penable/pwrite    paddr, pwdata, prdata
//
// One transaction per cycle sustained while results are popped; an item's result
// passes through the command queue, then the back end into the result queue, and pops from there.
// The back end updates all counters for a command together.
// full rises only when the command queue is full; a full result queue stalls the back end, which lets it fill.
// Reset is asynchronous; no clearing pass, items are taken right after reset.
`timescale 1ns / 1ps

module clock_stopwatch_countdown_timer_unit
  import ccdt_pkg::*;
#(
  parameter int FifoDepth = FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  item_t             item_i,
  output logic              empty,
  input  logic              pop,
  output result_t           result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CmdW = $bits(cmd_e);
  localparam int ResW = $bits(result_t);

  cfg_t            cfg;
  logic            cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_e            cmd_in;
  logic [CmdW-1:0] cmd_out;
  logic            res_push, res_full;
  result_t         res_in;
  logic [ResW-1:0] res_out;

  // Classify incoming transactions
  ccdt_front u_front (
    .push_i     (push),
    .item_i     (item_i),
    .cmd_full_i (cmd_full),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // Queue commands between front and back
  ccdt_fifo #(
    .Width (CmdW),
    .Depth (FifoDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (CmdW'(cmd_in)),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // Execute commands against the counters
  ccdt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_e'(cmd_out)),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Hold results until popped
  ccdt_fifo #(
    .Width (ResW),
    .Depth (FifoDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign result_o = result_t'(res_out);

  // Configuration registers
  ccdt_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

endmodule

// ===== rtl/core/ccdt_fifo.sv =====
// Small register FIFO used for the command queue and the result queue.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module ccdt_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/ccdt_front.sv =====
// Front end: takes input transactions and classifies them into commands.
// Depends on ccdt_pkg; feeds the command queue.
`timescale 1ns / 1ps

module ccdt_front
  import ccdt_pkg::*;
(
  input  logic  push_i,
  input  item_t item_i,
  input  logic  cmd_full_i,
  output logic  full_o,
  output logic  cmd_push_o,
  output cmd_e  cmd_o
);

  // Map request type and key code onto one command
  function automatic cmd_e classify(item_t it);
    cmd_e c;
    c = CMD_NOP;
    case (it.req_type)
      REQ_TICK:       c = CMD_TICK;
      REQ_START_STOP: c = CMD_START_STOP;
      REQ_KEY: begin
        case (it.key_code)
          KEY_SEC_UP:    c = CMD_SEC_UP;
          KEY_SEC_DN:    c = CMD_SEC_DN;
          KEY_MIN_UP:    c = CMD_MIN_UP;
          KEY_MIN_DN:    c = CMD_MIN_DN;
          KEY_HOUR_UP:   c = CMD_HOUR_UP;
          KEY_HOUR_DN:   c = CMD_HOUR_DN;
          KEY_RUN_SET:   c = CMD_RUN_SET;
          KEY_NEXT_MODE: c = CMD_NEXT_MODE;
          default:       c = CMD_NOP;
        endcase
      end
      default:        c = CMD_NOP;
    endcase
    return c;
  endfunction

  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i && !cmd_full_i;
  assign cmd_o      = classify(item_i);

endmodule

// ===== rtl/core/ccdt_regs.sv =====
// Configuration registers behind an APB-style port.
// Depends on ccdt_pkg; drives the cfg_t struct to the back end.
`timescale 1ns / 1ps

module ccdt_regs
  import ccdt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output logic [DATA_W-1:0] prdata_o,
  output logic              pready_o,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic reg_idx;
  logic wr_en;

  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[ADDR_W-1];
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;

  // Decode the write transaction
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_TICK_STEP: cfg_d.tick_step = pwdata_i[6:0];
        REG_MIN_STOP:  cfg_d.min_stop  = pwdata_i[5:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_TICK_STEP: prdata_o = {{(DATA_W - 7){1'b0}}, cfg_q.tick_step};
      REG_MIN_STOP:  prdata_o = {{(DATA_W - 6){1'b0}}, cfg_q.min_stop};
      default:       prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_step <= TICK_STEP_RST;
      cfg_q.min_stop  <= MIN_STOP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/ccdt_back.sv =====
// Back end: holds the three counters and flags and executes one command a cycle unless the result queue is full.
// Depends on ccdt_pkg; reads the command queue, writes the result queue.
`timescale 1ns / 1ps

module ccdt_back
  import ccdt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    cmd_valid_i,
  input  cmd_e    cmd_i,
  output logic    cmd_pop_o,
  input  logic    res_full_i,
  output logic    res_push_o,
  output result_t res_o
);

  mode_e mode_q, mode_d;
  hms_t  clk_time_q, clk_time_d;
  hms_t  sw_time_q, sw_time_d;
  hms_t  cd_time_q, cd_time_d;
  logic  sw_run_q, sw_run_d;
  logic  cd_run_q, cd_run_d;
  logic  alarm_q, alarm_d;
  logic  fire;
  logic  step_ok;
  logic  cd_under;
  logic  sw_long;
  logic [11:0] sw_secs;
  hms_t  shown;

  // Add a sub-second step with carries; hours wrap at 24
  function automatic hms_t time_add(hms_t t, logic [6:0] step);
    hms_t        r;
    logic [10:0] sum;
    r   = t;
    sum = {1'b0, t.ms} + {4'b0, step};
    if (sum >= MS_PER_S) begin
      r.ms = 10'(sum - MS_PER_S);
      if (t.s < SM_MAX) begin
        r.s = t.s + 1'b1;
      end else begin
        r.s = '0;
        if (t.m < SM_MAX) begin
          r.m = t.m + 1'b1;
        end else begin
          r.m = '0;
          r.h = (t.h >= HOUR_MAX) ? '0 : t.h + 1'b1;
        end
      end
    end else begin
      r.ms = sum[9:0];
    end
    return r;
  endfunction

  // Subtract a step; caller guarantees the total is at least the step
  function automatic hms_t time_sub(hms_t t, logic [6:0] step);
    hms_t        r;
    logic [10:0] diff;
    r    = t;
    diff = {1'b0, t.ms} + MS_PER_S - {4'b0, step};
    if (t.ms >= {3'b0, step}) begin
      r.ms = t.ms - {3'b0, step};
    end else begin
      r.ms = diff[9:0];
      if (t.s != '0) begin
        r.s = t.s - 1'b1;
      end else begin
        r.s = SM_MAX;
        if (t.m != '0) begin
          r.m = t.m - 1'b1;
        end else begin
          r.m = SM_MAX;
          r.h = t.h - 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Minute up with carry into hours
  function automatic hms_t min_up(hms_t t);
    hms_t r;
    r = t;
    if (t.m < SM_MAX) begin
      r.m = t.m + 1'b1;
    end else begin
      r.m = '0;
      r.h = (t.h >= HOUR_MAX) ? '0 : t.h + 1'b1;
    end
    return r;
  endfunction

  // Minute down with borrow from hours, saturating at zero
  function automatic hms_t min_dn(hms_t t);
    hms_t r;
    r = t;
    if (t.m != '0) begin
      r.m = t.m - 1'b1;
    end else if (t.h != '0) begin
      r.m = SM_MAX;
      r.h = t.h - 1'b1;
    end
    return r;
  endfunction

  // Timer edit keys, only applied while the timer is stopped
  function automatic hms_t timer_edit(hms_t t, cmd_e c);
    hms_t r;
    r = t;
    case (c)
      CMD_SEC_UP: begin
        if (t.s < SM_MAX) begin
          r.s = t.s + 1'b1;
        end else begin
          r   = min_up(t);
          r.s = '0;
        end
      end
      CMD_SEC_DN: begin
        if (t.s != '0) begin
          r.s = t.s - 1'b1;
        end else if (t.m != '0 || t.h != '0) begin
          r   = min_dn(t);
          r.s = SM_MAX;
        end
      end
      CMD_MIN_UP: r = min_up(t);
      CMD_MIN_DN: r = min_dn(t);
      default:    r = t;
    endcase
    return r;
  endfunction

  // Clock edit keys: fields wrap on their own
  function automatic hms_t clock_edit(hms_t t, cmd_e c);
    hms_t r;
    r = t;
    case (c)
      CMD_MIN_UP:  r.m = (t.m >= SM_MAX) ? '0 : t.m + 1'b1;
      CMD_MIN_DN:  r.m = (t.m == '0) ? SM_MAX : t.m - 1'b1;
      CMD_HOUR_UP: r.h = (t.h >= HOUR_MAX) ? '0 : t.h + 1'b1;
      CMD_HOUR_DN: r.h = (t.h == '0) ? HOUR_MAX : t.h - 1'b1;
      default:     r = t;
    endcase
    return r;
  endfunction

  assign fire       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;

  assign step_ok  = (cfg_i.tick_step != '0) && (cfg_i.tick_step <= STEP_MAX);
  assign cd_under = (cd_time_q.h == '0) && (cd_time_q.m == '0) && (cd_time_q.s == '0)
                    && (cd_time_q.ms < {3'b0, cfg_i.tick_step});

  // Compare total elapsed seconds with the stop threshold; any hour is long enough
  assign sw_secs  = 12'(sw_time_q.m) * 12'd60 + 12'(sw_time_q.s);
  assign sw_long  = (sw_time_q.h != '0) || (sw_secs > 12'(cfg_i.min_stop));

  // Execute the command at the head of the queue
  always_comb begin
    mode_d     = mode_q;
    clk_time_d = clk_time_q;
    sw_time_d  = sw_time_q;
    cd_time_d  = cd_time_q;
    sw_run_d   = sw_run_q;
    cd_run_d   = cd_run_q;
    alarm_d    = alarm_q;
    case (cmd_i)
      CMD_TICK: begin
        alarm_d = 1'b0;
        if (step_ok) begin
          clk_time_d = time_add(clk_time_q, cfg_i.tick_step);
          if (sw_run_q) begin
            sw_time_d = time_add(sw_time_q, cfg_i.tick_step);
          end
          if (cd_run_q) begin
            if (cd_under) begin
              cd_run_d  = 1'b0;
              cd_time_d = '0;
              mode_d    = MODE_TIMER;
              alarm_d   = 1'b1;
            end else begin
              cd_time_d = time_sub(cd_time_q, cfg_i.tick_step);
            end
          end
        end
      end
      CMD_NEXT_MODE: begin
        case (mode_q)
          MODE_TIMER:     mode_d = MODE_STOPWATCH;
          MODE_STOPWATCH: mode_d = MODE_CLOCK;
          default:        mode_d = MODE_TIMER;
        endcase
      end
      CMD_RUN_SET: begin
        case (mode_q)
          MODE_TIMER: cd_run_d = !cd_run_q;
          MODE_STOPWATCH: begin
            sw_run_d = !sw_run_q;
            if (!sw_run_q) begin
              sw_time_d = '0;
            end
          end
          default: sw_run_d = sw_run_q;
        endcase
      end
      CMD_START_STOP: begin
        if (sw_run_q) begin
          if (sw_long) begin
            sw_run_d = 1'b0;
          end
        end else begin
          sw_run_d  = 1'b1;
          sw_time_d = '0;
        end
      end
      CMD_SEC_UP, CMD_SEC_DN, CMD_MIN_UP, CMD_MIN_DN, CMD_HOUR_UP, CMD_HOUR_DN: begin
        if (mode_q == MODE_TIMER && !cd_run_q) begin
          cd_time_d = timer_edit(cd_time_q, cmd_i);
        end else if (mode_q == MODE_CLOCK) begin
          clk_time_d = clock_edit(clk_time_q, cmd_i);
        end
      end
      default: alarm_d = alarm_q;
    endcase
  end

  // Select the shown counter from the updated state
  always_comb begin
    case (mode_d)
      MODE_TIMER:     shown = cd_time_d;
      MODE_STOPWATCH: shown = sw_time_d;
      default:        shown = clk_time_d;
    endcase
    res_o.shown_mode        = mode_d;
    res_o.shown_hours       = shown.h;
    res_o.shown_minutes     = shown.m;
    res_o.shown_seconds     = shown.s;
    res_o.shown_millis      = shown.ms;
    res_o.alarm_active      = alarm_d;
    res_o.stopwatch_running = sw_run_d;
    res_o.countdown_running = cd_run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_STOPWATCH;
      clk_time_q <= '0;
      sw_time_q  <= '0;
      cd_time_q  <= '0;
      sw_run_q   <= 1'b0;
      cd_run_q   <= 1'b0;
      alarm_q    <= 1'b0;
    end else if (fire) begin
      mode_q     <= mode_d;
      clk_time_q <= clk_time_d;
      sw_time_q  <= sw_time_d;
      cd_time_q  <= cd_time_d;
      sw_run_q   <= sw_run_d;
      cd_run_q   <= cd_run_d;
      alarm_q    <= alarm_d;
    end
  end

endmodule

// ===== rtl/core/ccdt_checker.sv =====
// Port-level checker for the timer unit, bound to the top level.
// Depends on ccdt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccdt_checker
  import ccdt_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    push,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result_o
);

  logic [3:0] pend_q, pend_d;
  logic       in_acc, out_acc;
  logic       time_ok;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  // Flag a shown time whose fields are all in range
  assign time_ok = (result_o.shown_hours <= HOUR_MAX) && (result_o.shown_minutes <= SM_MAX)
                   && (result_o.shown_seconds <= SM_MAX) && (result_o.shown_millis <= MS_MAX);

  // Track transactions taken but not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `ASSERT_IMPLIES(a_no_invented, clk_i, rst_ni, pend_q == '0, empty, "result without item")
  `ASSERT_IMPLIES(a_time_range, clk_i, rst_ni, !empty, time_ok, "time field out of range")
  `ASSERT_IMPLIES(a_mode_range, clk_i, rst_ni, !empty, result_o.shown_mode != 2'd3, "bad mode")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(result_o), "held changed")

endmodule

bind clock_stopwatch_countdown_timer_unit ccdt_checker u_ccdt_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
